// File: sv/cbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the counting Bloom filter.
package cbf_pkg;

   localparam int unsigned FILTER_BITS_DEF = 65536;
   localparam int unsigned KEY_INDEX_WORDS = 16;
   localparam int unsigned KEY_IN_WORDS    = 8;
   localparam int unsigned KEY_IN_W        = 64;
   localparam int unsigned INDEX_WORD_W    = 32;
   localparam int unsigned HASH_W          = 5;
   localparam int unsigned CTR_W           = 4;
   localparam logic [CTR_W-1:0] CTR_MAX    = 4'hF;
   localparam logic [HASH_W-1:0] HASH_RESET = 5'd4;
   localparam logic [HASH_W-1:0] HASH_LIMIT = 5'd16;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASHES_PER_KEY   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTERS_ENABLED = 1'd1;

   typedef enum logic [1:0] {
      OP_TEST   = 2'd0,
      OP_ADD    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // One filter entry: membership bit and its usage counter.
   typedef struct packed {
      logic             member;
      logic [CTR_W-1:0] count;
   } cell_type;

   localparam int unsigned CELL_W = $bits(cell_type);

   // Result of the read-modify-write unit for one index.
   typedef struct packed {
      logic     wr;
      logic     present;
      cell_type entry;
   } upd_type;

endpackage

// File: sv/cbf_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module cbf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cbf_update.sv
`timescale 1ns / 1ps
// Per-index update rule: new entry value and write strobe for one operation.
module cbf_update import cbf_pkg::*; (
   input  op_type   op,
   input  logic     counters_en,
   input  cell_type rd_cell,
   output upd_type  upd
);

   always_comb begin
      logic [CTR_W-1:0] cnt_nxt;
      cnt_nxt     = rd_cell.count;
      upd         = '0;
      upd.entry   = rd_cell;
      case (op)
         OP_TEST: begin
            upd.present = rd_cell.member;
         end
         OP_ADD: begin
            upd.wr           = 1'b1;
            upd.entry.member = 1'b1;
            if (counters_en && rd_cell.count != CTR_MAX) begin
               upd.entry.count = rd_cell.count + CTR_W'(1);
            end
         end
         OP_DELETE: begin
            if (counters_en) begin
               // A saturated counter is sticky, so its bit stays set.
               if (rd_cell.count != '0 && rd_cell.count != CTR_MAX) begin
                  cnt_nxt = rd_cell.count - CTR_W'(1);
               end
               upd.wr          = 1'b1;
               upd.entry.count = cnt_nxt;
               if (cnt_nxt == '0) begin
                  upd.entry.member = 1'b0;
               end
            end
         end
         default: begin
            upd.wr = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/counting_bloom_filter.sv
`timescale 1ns / 1ps
// Counting Bloom filter with 4-bit saturating counters, one shared
// read-modify-write unit over a single RAM that holds bit and counter.
// Each index is read from the RAM, then updated and written back, and a test,
// add or delete beat walks its k indices this way before its result is
// offered; with k zero it goes straight to the result. A clear beat sweeps
// the RAM one entry a cycle and then offers a result. After reset the same
// sweep runs with the input stalled and no result.
// A new beat is taken as soon as the sequencer is idle, even while the
// previous result is still waiting on the output.
module counting_bloom_filter import cbf_pkg::*; #(
   parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [KEY_IN_W-1:0]    req_key_word0,
   input  logic [KEY_IN_W-1:0]    req_key_word1,
   input  logic [KEY_IN_W-1:0]    req_key_word2,
   input  logic [KEY_IN_W-1:0]    req_key_word3,
   input  logic [KEY_IN_W-1:0]    req_key_word4,
   input  logic [KEY_IN_W-1:0]    req_key_word5,
   input  logic [KEY_IN_W-1:0]    req_key_word6,
   input  logic [KEY_IN_W-1:0]    req_key_word7,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_member_present,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int unsigned ADDR_W = $clog2(FILTER_BITS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FILTER_BITS - 1);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] idx_ff [KEY_INDEX_WORDS];
   logic [ADDR_W-1:0] idx_in [KEY_INDEX_WORDS];
   logic [HASH_W-1:0] remain_ff, remain_in;
   logic              all_set_ff, all_set_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_member_present_ff, rsp_member_present_in;
   logic [HASH_W-1:0] hashes_ff;
   logic              counters_en_ff;

   logic [KEY_IN_W-1:0] key_words [KEY_IN_WORDS];
   logic [HASH_W-1:0]   k_eff;
   logic                req_accept;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   cell_type            ram_wdata;
   cell_type            ram_rdata;
   upd_type             upd;

   assign key_words[0] = req_key_word0;
   assign key_words[1] = req_key_word1;
   assign key_words[2] = req_key_word2;
   assign key_words[3] = req_key_word3;
   assign key_words[4] = req_key_word4;
   assign key_words[5] = req_key_word5;
   assign key_words[6] = req_key_word6;
   assign key_words[7] = req_key_word7;

   assign k_eff      = (hashes_ff > HASH_LIMIT) ? HASH_LIMIT : hashes_ff;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hashes_ff      <= HASH_RESET;
         counters_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HASHES_PER_KEY:   hashes_ff      <= csr_wr_data[HASH_W-1:0];
            CSR_COUNTERS_ENABLED: counters_en_ff <= csr_wr_data[0];
            default:              hashes_ff      <= hashes_ff;
         endcase
      end
   end

   cbf_ram #(
      .WIDTH (CELL_W),
      .DEPTH (FILTER_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   cbf_update u_update (
      .op          (op_ff),
      .counters_en (counters_en_ff),
      .rd_cell     (ram_rdata),
      .upd         (upd)
   );

   always_comb begin
      state_in              = state_ff;
      op_in                 = op_ff;
      idx_in                = idx_ff;
      remain_in             = remain_ff;
      all_set_in            = all_set_ff;
      sweep_in              = sweep_ff;
      clr_rsp_in            = clr_rsp_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rsp_member_present_in = rsp_member_present_ff;
      ram_we                = 1'b0;
      ram_addr              = idx_ff[0];
      ram_wdata             = upd.entry;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = op_type'(req_op);
               remain_in  = k_eff;
               all_set_in = 1'b1;
               sweep_in   = '0;
               clr_rsp_in = 1'b1;
               for (int i = 0; i < KEY_IN_WORDS; i++) begin
                  idx_in[2*i]   = key_words[i][ADDR_W-1:0];
                  idx_in[2*i+1] = key_words[i][INDEX_WORD_W +: ADDR_W];
               end
               if (op_type'(req_op) == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (k_eff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            ram_we     = upd.wr;
            all_set_in = all_set_ff && (op_ff != OP_TEST || upd.present);
            remain_in  = remain_ff - HASH_W'(1);
            for (int j = 0; j < KEY_INDEX_WORDS - 1; j++) begin
               idx_in[j] = idx_ff[j+1];
            end
            state_in = (remain_ff == HASH_W'(1)) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_member_present_in = (op_ff == OP_TEST) && all_set_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff                 <= op_in;
      idx_ff                <= idx_in;
      all_set_ff            <= all_set_in;
      rsp_member_present_ff <= rsp_member_present_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_member_present = rsp_member_present_ff;

   // A new result only appears when the sequencer finishes a beat.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside of the done state");

   // A membership test must never disturb the store.
   a_test_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY && op_ff == OP_TEST) |-> !ram_we)
      else $error("store written during a test");

   // The index walk always has at least one index left while it runs.
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_MODIFY) |-> remain_ff != '0)
      else $error("index walk running with nothing left");

   // Every modify step follows its read step.
   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> $past(state_ff == ST_READ))
      else $error("modify step without a preceding read");

endmodule

// File: verif/counting_bloom_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the counting Bloom filter: directed cases, then random traffic.
module counting_bloom_filter_tb;
   import cbf_pkg::*;

   localparam int unsigned IDX_W          = $clog2(FILTER_BITS_DEF);
   localparam int unsigned KEY_W          = KEY_IN_W * KEY_IN_WORDS;
   localparam int unsigned POOL_SIZE      = 24;
   localparam int          DRAIN_SETTLE   = 2 * KEY_INDEX_WORDS + 8;
   localparam int          WATCHDOG_LIMIT = 4 * FILTER_BITS_DEF;
   localparam int          PHASE_ITEMS    = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_op = OP_TEST;
   logic [KEY_W-1:0]       req_key = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_member_present;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HASHES_PER_KEY;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Mirror of the filter contents and its configuration.
   logic [CTR_W-1:0]  ctr_store [FILTER_BITS_DEF];
   bit                bit_store [FILTER_BITS_DEF];
   logic [HASH_W-1:0] hash_count = HASH_RESET;
   bit                counting_on = 1'b1;

   bit               expected_presence [$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               hold_off_left = 0;
   logic [IDX_W-1:0] index_pool [POOL_SIZE];

   counting_bloom_filter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_key_word0      (req_key[0*KEY_IN_W +: KEY_IN_W]),
      .req_key_word1      (req_key[1*KEY_IN_W +: KEY_IN_W]),
      .req_key_word2      (req_key[2*KEY_IN_W +: KEY_IN_W]),
      .req_key_word3      (req_key[3*KEY_IN_W +: KEY_IN_W]),
      .req_key_word4      (req_key[4*KEY_IN_W +: KEY_IN_W]),
      .req_key_word5      (req_key[5*KEY_IN_W +: KEY_IN_W]),
      .req_key_word6      (req_key[6*KEY_IN_W +: KEY_IN_W]),
      .req_key_word7      (req_key[7*KEY_IN_W +: KEY_IN_W]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_member_present (rsp_member_present),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_filter_model();
      foreach (ctr_store[i]) begin
         ctr_store[i] = '0;
         bit_store[i] = 1'b0;
      end
   endfunction

   // Applies one operation to the mirrored filter and returns the expected presence flag.
   function automatic bit apply_filter_op(input op_type op, input logic [KEY_W-1:0] key_bits);
      int unsigned      k;
      int unsigned      n;
      logic [IDX_W-1:0] idx;
      logic [CTR_W-1:0] c;
      bit               all_set;
      all_set = 1'b1;
      if (op == OP_CLEAR) begin
         clear_filter_model();
         return 1'b0;
      end
      k = (hash_count > HASH_LIMIT) ? HASH_LIMIT : hash_count;
      // Indices are handled in order, so a repeated index is counted twice.
      for (n = 0; n < k; n++) begin
         idx = key_bits[INDEX_WORD_W*n +: IDX_W];
         c = ctr_store[idx];
         case (op)
            OP_TEST: begin
               if (!bit_store[idx]) all_set = 1'b0;
            end
            OP_ADD: begin
               bit_store[idx] = 1'b1;
               if (counting_on && c != CTR_MAX) ctr_store[idx] = c + 1'b1;
            end
            OP_DELETE: begin
               if (counting_on) begin
                  // A saturated counter no longer knows its true count, so it sticks.
                  if (c != 0 && c != CTR_MAX) c = c - 1'b1;
                  ctr_store[idx] = c;
                  if (c == 0) bit_store[idx] = 1'b0;
               end
            end
            default: ;
         endcase
      end
      return (op == OP_TEST) && all_set;
   endfunction

   // Draws the low index bits from a small pool for pool_pct percent of the words so that keys collide often.
   function automatic logic [KEY_W-1:0] random_key(input int pool_pct);
      logic [KEY_W-1:0]        key_bits;
      logic [INDEX_WORD_W-1:0] word;
      int unsigned             n;
      for (n = 0; n < KEY_INDEX_WORDS; n++) begin
         word = $urandom;
         if ($urandom_range(99) < pool_pct) word[IDX_W-1:0] = index_pool[$urandom_range(POOL_SIZE-1)];
         key_bits[INDEX_WORD_W*n +: INDEX_WORD_W] = word;
      end
      return key_bits;
   endfunction

   // Every index word points at the same entry; the unused high bits stay random.
   function automatic logic [KEY_W-1:0] index_key(input logic [IDX_W-1:0] idx);
      logic [KEY_W-1:0]        key_bits;
      logic [INDEX_WORD_W-1:0] word;
      int unsigned             n;
      for (n = 0; n < KEY_INDEX_WORDS; n++) begin
         word = $urandom;
         word[IDX_W-1:0] = idx;
         key_bits[INDEX_WORD_W*n +: INDEX_WORD_W] = word;
      end
      return key_bits;
   endfunction

   // Offers one beat and returns at the edge where it is taken, with valid still high.
   task automatic send_item(input op_type op, input logic [KEY_W-1:0] key_bits);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_key <= key_bits;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_presence.push_back(apply_filter_op(op, key_bits));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_presence.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned hashes, input bit counting);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HASHES_PER_KEY;
      csr_wr_data <= hashes[CSR_DATA_W-1:0];
      @(posedge clock);
      hash_count = hashes[HASH_W-1:0];
      csr_index <= CSR_COUNTERS_ENABLED;
      csr_wr_data <= CSR_DATA_W'(counting);
      @(posedge clock);
      counting_on = counting;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_empty_filter();
      send_item(OP_TEST, '0);
      send_item(OP_TEST, '1);
   endtask

   task automatic test_add_then_query();
      logic [KEY_W-1:0] key_bits;
      key_bits = random_key(0);
      send_item(OP_ADD, key_bits);
      send_item(OP_TEST, key_bits);
   endtask

   // One add with all sixteen indices on one entry saturates its counter; a delete must leave it there.
   task automatic test_counter_saturation();
      logic [KEY_W-1:0] key_bits;
      key_bits = index_key(index_pool[0]);
      set_config(KEY_INDEX_WORDS, 1'b1);
      send_item(OP_ADD, key_bits);
      send_item(OP_DELETE, key_bits);
      send_item(OP_TEST, key_bits);
   endtask

   task automatic test_delete_to_zero();
      logic [KEY_W-1:0] key_bits;
      key_bits = index_key(index_pool[1]);
      set_config(1, 1'b1);
      send_item(OP_ADD, key_bits);
      send_item(OP_ADD, key_bits);
      send_item(OP_DELETE, key_bits);
      send_item(OP_TEST, key_bits);
      send_item(OP_DELETE, key_bits);
      send_item(OP_TEST, key_bits);
      send_item(OP_DELETE, key_bits);
   endtask

   // A bit set with counters off has a zero counter, so a later delete clears it.
   task automatic test_counters_disabled();
      logic [KEY_W-1:0] key_bits;
      key_bits = index_key(index_pool[2]);
      set_config(1, 1'b0);
      send_item(OP_ADD, key_bits);
      send_item(OP_DELETE, key_bits);
      send_item(OP_TEST, key_bits);
      set_config(1, 1'b1);
      send_item(OP_DELETE, key_bits);
      send_item(OP_TEST, key_bits);
   endtask

   task automatic test_hash_count_edges();
      set_config(0, 1'b1);
      send_item(OP_TEST, random_key(0));
      send_item(OP_ADD, random_key(0));
      set_config(31, 1'b1);
      send_item(OP_ADD, '1);
      send_item(OP_TEST, '1);
      set_config(17, 1'b1);
      send_item(OP_TEST, random_key(100));
   endtask

   task automatic test_clear();
      send_item(OP_CLEAR, random_key(0));
      send_item(OP_TEST, '1);
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      int unsigned n;
      set_config(HASH_RESET, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_off_left <= 300;
      for (n = 0; n < 10; n++) begin
         send_item($urandom_range(1) ? OP_ADD : OP_TEST, random_key(100));
      end
      drain_results();
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int unsigned chunk;
      int unsigned n;
      int unsigned pick;
      int unsigned hashes;
      op_type      op;
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      for (chunk = 0; chunk < 3; chunk++) begin
         pick = $urandom_range(9);
         if (pick == 0) hashes = 0;
         else if (pick == 1) hashes = $urandom_range(31, 17);
         else hashes = $urandom_range(16, 1);
         set_config(hashes, $urandom_range(3) != 0);
         for (n = 0; n < PHASE_ITEMS / 3; n++) begin
            pick = $urandom_range(999);
            // Clears are rare because each one sweeps the whole array.
            if (pick < 4) op = OP_CLEAR;
            else if (pick < 400) op = OP_TEST;
            else if (pick < 720) op = OP_ADD;
            else op = OP_DELETE;
            send_item(op, random_key($urandom_range(4) == 0 ? 0 : 95));
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_presence.size() == 0) begin
            $error("member_present: no beat expected, actual %0b", rsp_member_present);
            mismatch_count++;
         end else begin
            want = expected_presence.pop_front();
            if (rsp_member_present !== want) begin
               $error("member_present: expected %0b, actual %0b", want, rsp_member_present);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int unsigned n;
      clear_filter_model();
      for (n = 0; n < POOL_SIZE; n++) index_pool[n] = IDX_W'($urandom);
      index_pool[0] = '0;
      index_pool[POOL_SIZE-1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_filter();
      test_add_then_query();
      test_counter_saturation();
      test_delete_to_zero();
      test_counters_disabled();
      test_hash_count_edges();
      test_clear();
      test_backpressure();
      run_random_phase(0, 0);
      run_random_phase(88, 0);
      run_random_phase(0, 88);
      run_random_phase(13, 13);
      drain_results();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/cbf_pkg.sv
sv/cbf_ram.sv
sv/cbf_update.sv
sv/counting_bloom_filter.sv
verif/counting_bloom_filter_tb.sv
